### hdl/lsbx_pkg.sv
// Package for the LSB steganography extractor: field widths, result kind codes
// and register indexes. No dependencies.
package lsbx_pkg;

  localparam int MAX_SIGNATURE = 8;
  localparam int SIG_LEN_W     = 4;
  localparam int HDR_W         = 10;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 32;
  localparam int BITCNT_W      = 5;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 5;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_EXT_CHAR = 2'd0;
  localparam kind_t KIND_PAYLOAD  = 2'd1;
  localparam kind_t KIND_SIG_ERR  = 2'd2;
  localparam kind_t KIND_EMPTY    = 2'd3;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_HEADER_SKIP  = 2'd0;
  localparam reg_idx_t REG_MAGIC_LENGTH = 2'd1;
  localparam reg_idx_t REG_MAGIC_WORD   = 2'd2;

  localparam logic [HDR_W-1:0]     HEADER_SKIP_RST  = 10'd54;
  localparam logic [SIG_LEN_W-1:0] MAGIC_LENGTH_RST = 4'd0;
  localparam logic [CFG_DATA_W-1:0] MAGIC_WORD_RST  = 64'd0;

endpackage

### hdl/lsb_stego_extractor.sv
// LSB steganography extractor: header skip, signature check, extension and
// payload recovery from image byte LSBs. Depends on lsbx_pkg.
//
// Usage:
//   Image bytes enter on the in_ channel (valid/ready), one per transaction.
//   in_image_start marks the first byte of a new image and restarts parsing.
//   Recovered characters and status results leave on the out_ channel:
//   out_kind tells extension char, payload byte, signature mismatch or empty
//   payload; out_last flags the final payload byte and both status results.
//   Registers (header_skip, magic_length, magic_word) sit on an APB port at
//   byte addresses 0, 8 and 16 with 64-bit data; write them while idle.
// Timing:
//   A byte is captured in an input register, then parsed into the result
//   register once the result slot is free.
//   One byte per cycle sustained while results are taken; the only other
//   limit is the single parse stage between the input and result registers.
// Reset and stall:
//   Reset restores register defaults and puts the parser in header skip.
//   While the receiver stalls, the held result blocks the parse stage; the
//   input register takes one more byte if it is empty, then in_ready drops.
module lsb_stego_extractor (
  input  logic                               clk,
  input  logic                               rst_n,
  // image byte channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lsbx_pkg::BYTE_W-1:0]        in_pixel_byte,
  input  logic                               in_image_start,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lsbx_pkg::BYTE_W-1:0]        out_byte,
  output lsbx_pkg::kind_t                    out_kind,
  output logic                               out_last,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lsbx_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lsbx_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lsbx_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import lsbx_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIG,
    PH_EXTLEN,
    PH_EXTCH,
    PH_PAYLEN,
    PH_PAY,
    PH_HALT
  } phase_t;

  // configuration registers
  logic [HDR_W-1:0]      header_skip_r;
  logic [SIG_LEN_W-1:0]  magic_length_r;
  logic [CFG_DATA_W-1:0] magic_word_r;

  // input register
  logic in_v_r;
  logic in_bit_r;
  logic in_start_r;

  // parser state
  phase_t                phase_r, phase_nxt;
  logic [HDR_W-1:0]      header_count_r, header_count_nxt;
  logic [BITCNT_W-1:0]   bit_count_r, bit_count_nxt;
  logic [WORD_W-1:0]     bit_gather_r, bit_gather_nxt;
  logic [SIG_LEN_W-1:0]  sig_index_r, sig_index_nxt;
  logic [WORD_W-1:0]     remaining_r, remaining_nxt;

  // result register
  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  kind_t                 out_kind_r, out_kind_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  res_nxt;

  logic                  proc_go;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  logic [SIG_LEN_W-1:0]  sig_len;

  // working copies after an optional restart
  phase_t                ph;
  logic [HDR_W-1:0]      hc;
  logic [BITCNT_W-1:0]   bc;
  logic [WORD_W-1:0]     bg;
  logic [SIG_LEN_W-1:0]  si;
  logic [WORD_W-1:0]     rem;
  logic                  skipped;
  logic [BITCNT_W:0]     need;
  logic [WORD_W-1:0]     word;
  logic                  full;
  logic [BYTE_W-1:0]     sig_byte;
  logic [WORD_W-1:0]     rem_dec;
  logic [SIG_LEN_W-1:0]  si_inc;

  // APB decode
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_HEADER_SKIP:  prdata = CFG_DATA_W'(header_skip_r);
      REG_MAGIC_LENGTH: prdata = CFG_DATA_W'(magic_length_r);
      REG_MAGIC_WORD:   prdata = magic_word_r;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r  <= HEADER_SKIP_RST;
      magic_length_r <= MAGIC_LENGTH_RST;
      magic_word_r   <= MAGIC_WORD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HEADER_SKIP:  header_skip_r  <= pwdata[HDR_W-1:0];
        REG_MAGIC_LENGTH: magic_length_r <= pwdata[SIG_LEN_W-1:0];
        REG_MAGIC_WORD:   magic_word_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // handshake: parse when a byte is held and the result slot is free
  assign proc_go  = in_v_r && (!out_valid_r || out_ready);
  assign in_ready = !in_v_r || proc_go;

  assign sig_len = (magic_length_r > SIG_LEN_W'(MAX_SIGNATURE)) ?
                   SIG_LEN_W'(MAX_SIGNATURE) : magic_length_r;

  // parse one hidden bit
  always_comb begin
    if (in_start_r) begin
      ph  = PH_HEADER;
      hc  = '0;
      bc  = '0;
      bg  = '0;
      si  = '0;
      rem = '0;
    end else begin
      ph  = phase_r;
      hc  = header_count_r;
      bc  = bit_count_r;
      bg  = bit_gather_r;
      si  = sig_index_r;
      rem = remaining_r;
    end

    skipped = 1'b0;
    header_count_nxt = hc;
    if (ph == PH_HEADER) begin
      if (hc < header_skip_r) begin
        header_count_nxt = hc + 1'b1;
        skipped = 1'b1;
      end else begin
        ph = (sig_len != '0) ? PH_SIG : PH_EXTLEN;
      end
    end

    // bit gathering, first bit lands in bit 0
    need     = (ph == PH_EXTLEN || ph == PH_PAYLEN) ? (BITCNT_W+1)'(WORD_W) :
                                                     (BITCNT_W+1)'(BYTE_W);
    word     = bg | (WORD_W'(in_bit_r) << bc);
    full     = ((BITCNT_W+1)'(bc) + 1'b1) >= need;
    sig_byte = magic_word_r[{si[2:0], 3'b000} +: BYTE_W];
    rem_dec  = rem - 1'b1;
    si_inc   = si + 1'b1;

    phase_nxt      = ph;
    bit_count_nxt  = bc;
    bit_gather_nxt = bg;
    sig_index_nxt  = si;
    remaining_nxt  = rem;
    res_nxt        = 1'b0;
    out_byte_nxt   = '0;
    out_kind_nxt   = KIND_EXT_CHAR;
    out_last_nxt   = 1'b0;

    if (!skipped && ph != PH_HALT && ph != PH_HEADER) begin
      bit_count_nxt  = full ? '0 : bc + 1'b1;
      bit_gather_nxt = full ? '0 : word;
    end

    if (!skipped && full) begin
      case (ph)
        PH_SIG: begin
          if (word[BYTE_W-1:0] != sig_byte) begin
            phase_nxt    = PH_HALT;
            res_nxt      = 1'b1;
            out_kind_nxt = KIND_SIG_ERR;
            out_last_nxt = 1'b1;
          end else begin
            sig_index_nxt = si_inc;
            if (si_inc >= sig_len) phase_nxt = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          remaining_nxt = word >> 3;
          phase_nxt     = ((word >> 3) != '0) ? PH_EXTCH : PH_PAYLEN;
        end
        PH_EXTCH: begin
          remaining_nxt = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_PAYLEN;
          res_nxt      = 1'b1;
          out_byte_nxt = word[BYTE_W-1:0];
          out_kind_nxt = KIND_EXT_CHAR;
        end
        PH_PAYLEN: begin
          remaining_nxt = word;
          if (word == '0) begin
            phase_nxt    = PH_HALT;
            res_nxt      = 1'b1;
            out_kind_nxt = KIND_EMPTY;
            out_last_nxt = 1'b1;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          remaining_nxt = rem_dec;
          res_nxt       = 1'b1;
          out_byte_nxt  = word[BYTE_W-1:0];
          out_kind_nxt  = KIND_PAYLOAD;
          out_last_nxt  = (rem_dec == '0);
          if (rem_dec == '0) phase_nxt = PH_HALT;
        end
        default: phase_nxt = PH_HALT;
      endcase
    end else if (!skipped && ph != PH_HEADER && ph != PH_SIG && ph != PH_EXTLEN &&
                 ph != PH_EXTCH && ph != PH_PAYLEN && ph != PH_PAY) begin
      // halted or unused code: stay halted
      phase_nxt = PH_HALT;
    end
  end

  // input register: hold the byte until parsed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_bit_r   <= in_pixel_byte[0];
      in_start_r <= in_image_start;
    end
  end

  // parser state: advance on each parsed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= '0;
      bit_count_r    <= '0;
      bit_gather_r   <= '0;
      sig_index_r    <= '0;
      remaining_r    <= '0;
    end else if (proc_go) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      bit_gather_r   <= bit_gather_nxt;
      sig_index_r    <= sig_index_nxt;
      remaining_r    <= remaining_nxt;
    end
  end

  // result register: load on parse, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go) begin
      out_valid_r <= res_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_nxt) begin
      out_byte_r <= out_byte_nxt;
      out_kind_r <= out_kind_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule
